### design/rc4_pkg.sv
// Shared constants, types and sequencer states for the RC4 engine.
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int MEM_DEPTH     = 256;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);
  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_LEN_W     = 9;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

  localparam logic [1:0] MODE_KEY_WRITE = 2'd0;
  localparam logic [1:0] MODE_SCHEDULE  = 2'd1;
  localparam logic [1:0] MODE_CRYPT     = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_READ,
    ST_KS_ADD,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_PG_ADD,
    ST_PG_WR_X,
    ST_PG_WR_Y,
    ST_PG_READ_K,
    ST_PG_OUT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } result_t;

endpackage

### design/rc4_stream_cipher_top.sv
// RC4 engine top level: key length register, core and output register.
// Key byte write: stored when accepted. Data byte: PG_ADD, PG_WR_X, PG_WR_Y, PG_READ_K, PG_OUT
// to the result register, taking no new byte meanwhile: permutation memory accesses are serial.
// Key schedule: a fill pass, then KS_READ, KS_ADD, KS_WR_I and KS_WR_J for each swap step.
// Reset clears the sequencer, stream indices, keyed flag and output valid, and
// sets key_length to 16; the permutation and key memories are not cleared.
module rc4_stream_cipher_top
  import rc4_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [KEY_LEN_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [ADDR_W-1:0]    key_index_i,
  input  logic [BYTE_W-1:0]    value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    data_out_o
);

  logic [KEY_LEN_W-1:0] key_len_q;
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_data_q;
  logic                 out_free;
  result_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KEY_LEN_RESET;
    end else if (cfg_we_i) begin
      key_len_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  rc4_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_len_i  (key_len_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .key_index_i(key_index_i),
    .value_i    (value_i),
    .out_free_i (out_free),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  // Load a new result only when the register is empty or being drained.
  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

endmodule

### design/rc4_ram.sv
// Single write port, single registered read port byte memory.
module rc4_ram
  import rc4_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [MEM_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/rc4_core.sv
// Sequencer for key writes, key schedule and keystream steps around one shared byte adder.
module rc4_core
  import rc4_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_LEN_W-1:0] key_len_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [ADDR_W-1:0]    key_index_i,
  input  logic [BYTE_W-1:0]    value_i,
  input  logic                 out_free_i,
  output result_t              res_o
);

  state_e state_q, state_d;

  logic [ADDR_W-1:0]    i_q, i_d;
  logic [ADDR_W-1:0]    j_q, j_d;
  logic [KEY_LEN_W-1:0] k_q, k_d;
  logic [ADDR_W-1:0]    x_q, x_d;
  logic [ADDR_W-1:0]    y_q, y_d;
  logic                 keyed_q, keyed_d;
  logic [BYTE_W-1:0]    t_q, t_d;
  logic [BYTE_W-1:0]    b_q, b_d;
  logic [BYTE_W-1:0]    val_q, val_d;

  logic                 perm_we;
  logic [ADDR_W-1:0]    perm_waddr;
  logic [BYTE_W-1:0]    perm_wdata;
  logic [ADDR_W-1:0]    perm_raddr;
  logic [BYTE_W-1:0]    perm_rdata;

  logic                 key_we;
  logic [BYTE_W-1:0]    key_rdata;

  logic [BYTE_W-1:0]    add_a, add_b, add_c, add_sum;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_LEN_W-1:0] k_inc;
  logic                 accept;

  rc4_ram u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (perm_we),
    .waddr_i(perm_waddr),
    .wdata_i(perm_wdata),
    .raddr_i(perm_raddr),
    .rdata_o(perm_rdata)
  );

  rc4_ram u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_index_i),
    .wdata_i(value_i),
    .raddr_i(k_q[ADDR_W-1:0]),
    .rdata_o(key_rdata)
  );

  // Clamp the key length to the usable range.
  always_comb begin
    if (key_len_i == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_len_i > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      eff_len = key_len_i;
    end
  end

  assign k_inc   = k_q + KEY_LEN_W'(1);
  assign add_sum = add_a + add_b + add_c;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign key_we     = accept && (mode_i == MODE_KEY_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      x_q     <= '0;
      y_q     <= '0;
      keyed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      x_q     <= x_d;
      y_q     <= y_d;
      keyed_q <= keyed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    b_q   <= b_d;
    val_q <= val_d;
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    x_d        = x_q;
    y_d        = y_q;
    keyed_d    = keyed_q;
    t_d        = t_q;
    b_d        = b_q;
    val_d      = val_q;
    perm_we    = 1'b0;
    perm_waddr = i_q;
    perm_wdata = i_q;
    perm_raddr = i_q;
    add_a      = '0;
    add_b      = '0;
    add_c      = '0;
    res_o      = '{valid: 1'b0, data: '0};

    case (state_q)
      ST_IDLE: begin
        // Advance x and fetch S[x] as the crypt request is taken.
        add_a      = x_q;
        add_c      = BYTE_W'(1);
        perm_raddr = add_sum;
        if (accept) begin
          if (mode_i == MODE_SCHEDULE) begin
            i_d     = '0;
            state_d = ST_INIT;
          end else if (mode_i == MODE_CRYPT && keyed_q) begin
            x_d     = add_sum;
            val_d   = value_i;
            state_d = ST_PG_ADD;
          end
        end
      end

      ST_INIT: begin
        perm_we = 1'b1;
        i_d     = i_q + ADDR_W'(1);
        if (i_q == ADDR_W'(MEM_DEPTH - 1)) begin
          j_d     = '0;
          k_d     = '0;
          state_d = ST_KS_READ;
        end
      end

      ST_KS_READ: begin
        state_d = ST_KS_ADD;
      end

      ST_KS_ADD: begin
        add_a      = j_q;
        add_b      = perm_rdata;
        add_c      = key_rdata;
        t_d        = perm_rdata;
        j_d        = add_sum;
        perm_raddr = add_sum;
        state_d    = ST_KS_WR_I;
      end

      ST_KS_WR_I: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rdata;
        state_d    = ST_KS_WR_J;
      end

      ST_KS_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = t_q;
        k_d        = (k_inc >= eff_len) ? '0 : k_inc;
        i_d        = i_q + ADDR_W'(1);
        if (i_q == ADDR_W'(MEM_DEPTH - 1)) begin
          x_d     = '0;
          y_d     = '0;
          keyed_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KS_READ;
        end
      end

      ST_PG_ADD: begin
        add_a      = y_q;
        add_b      = perm_rdata;
        t_d        = perm_rdata;
        y_d        = add_sum;
        perm_raddr = add_sum;
        state_d    = ST_PG_WR_X;
      end

      ST_PG_WR_X: begin
        perm_we    = 1'b1;
        perm_waddr = x_q;
        perm_wdata = perm_rdata;
        b_d        = perm_rdata;
        state_d    = ST_PG_WR_Y;
      end

      ST_PG_WR_Y: begin
        perm_we    = 1'b1;
        perm_waddr = y_q;
        perm_wdata = t_q;
        state_d    = ST_PG_READ_K;
      end

      ST_PG_READ_K: begin
        add_a      = t_q;
        add_b      = b_q;
        perm_raddr = add_sum;
        state_d    = ST_PG_OUT;
      end

      ST_PG_OUT: begin
        // Hold the keystream address so the read data stays put while stalled.
        add_a      = t_q;
        add_b      = b_q;
        perm_raddr = add_sum;
        res_o      = '{valid: 1'b1, data: val_q ^ perm_rdata};
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
